@@ sv/tlt_pkg.sv @@
package tlt_pkg;

  localparam int MaxRes     = 4;
  localparam int CntW       = 3;
  localparam int QueueDepth = 4;

  localparam logic [3:0] KindIdent       = 4'd0;
  localparam logic [3:0] KindNumber      = 4'd1;
  localparam logic [3:0] KindString      = 4'd2;
  localparam logic [3:0] KindAssign      = 4'd3;
  localparam logic [3:0] KindPlusAssign  = 4'd4;
  localparam logic [3:0] KindMinusAssign = 4'd5;
  localparam logic [3:0] KindMultAssign  = 4'd6;
  localparam logic [3:0] KindSemicolon   = 4'd7;
  localparam logic [3:0] KindPrint       = 4'd8;
  localparam logic [3:0] KindFor         = 4'd9;
  localparam logic [3:0] KindEndfor      = 4'd10;
  localparam logic [3:0] KindEof         = 4'd11;
  localparam logic [3:0] KindBadChar     = 4'd12;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       source_end;
  } in_t;

  typedef struct packed {
    logic [7:0] value_char;
    logic       char_present;
    logic       token_end;
    logic [3:0] token_kind;
    logic       last;
  } out_t;

  typedef struct packed {
    out_t [MaxRes-1:0] res;
    logic [CntW-1:0]   cnt;
  } bundle_t;

endpackage

@@ sv/tlt_front.sv @@
module tlt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  tlt_pkg::in_t     in_i,
  output logic             wr_o,
  output tlt_pkg::bundle_t bundle_o
);
  import tlt_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeIdent,
    ModeNumber,
    ModeString
  } mode_e;

  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldPlus  = 2'd1;
  localparam logic [1:0] HeldMinus = 2'd2;
  localparam logic [1:0] HeldStar  = 2'd3;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;

  mode_e      mode_q, mode_d;
  logic [1:0] held_q, held_d;
  logic [2:0] alive_q, alive_d;
  logic [2:0] wlen_q, wlen_d;
  bundle_t    b;
  logic [7:0] c;
  logic       fresh;

  function automatic logic is_digit(input logic [7:0] x);
    return (x >= 8'h30) && (x <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] x);
    return ((x >= 8'h41) && (x <= 8'h5a)) || ((x >= 8'h61) && (x <= 8'h7a));
  endfunction

  function automatic logic is_space(input logic [7:0] x);
    return (x == 8'h20) || ((x >= 8'h09) && (x <= 8'h0d));
  endfunction

  function automatic logic is_word(input logic [7:0] x);
    return is_alpha(x) || is_digit(x) || (x == ChUnder);
  endfunction

  function automatic logic [7:0] op_char(input logic [1:0] h);
    logic [7:0] r;
    case (h)
      HeldPlus:  r = ChPlus;
      HeldMinus: r = ChMinus;
      HeldStar:  r = ChStar;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] r;
    case (k)
      0:       r = 3'd5;
      1:       r = 3'd3;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_kind(input int k);
    logic [3:0] r;
    case (k)
      0:       r = KindPrint;
      1:       r = KindFor;
      default: r = KindEndfor;
    endcase
    return r;
  endfunction

  function automatic logic kw_match(input int k, input logic [2:0] i, input logic [7:0] x);
    logic [47:0] w;
    logic [2:0]  sh;
    logic        m;
    case (k)
      0:       w = {"PRINT", 8'h00};
      1:       w = {"FOR", 24'h000000};
      default: w = "ENDFOR";
    endcase
    sh = 3'd5 - i;
    m  = 1'b0;
    if (i < kw_len(k)) begin
      m = (w[{sh, 3'b000} +: 8] == x);
    end
    return m;
  endfunction

  function automatic bundle_t emit(input bundle_t bi, input logic [7:0] ch, input logic pr,
                                   input logic en, input logic [3:0] kind);
    bundle_t bo;
    bo = bi;
    if (bi.cnt < CntW'(MaxRes)) begin
      bo.res[bi.cnt[1:0]].value_char   = ch;
      bo.res[bi.cnt[1:0]].char_present = pr;
      bo.res[bi.cnt[1:0]].token_end    = en;
      bo.res[bi.cnt[1:0]].token_kind   = en ? kind : KindIdent;
      bo.res[bi.cnt[1:0]].last         = 1'b0;
      bo.cnt = bi.cnt + CntW'(1);
    end
    return bo;
  endfunction

  function automatic logic [3:0] ident_kind(input logic [2:0] al, input logic [2:0] wl);
    logic [3:0] r;
    r = KindIdent;
    for (int k = 0; k < 3; k++) begin
      if (al[k] && (wl == kw_len(k))) begin
        r = kw_kind(k);
      end
    end
    return r;
  endfunction

  always_comb begin
    b       = '0;
    mode_d  = mode_q;
    held_d  = held_q;
    alive_d = alive_q;
    wlen_d  = wlen_q;
    c       = in_i.text_byte;
    fresh   = 1'b0;
    if (in_i.byte_present) begin
      fresh = 1'b1;
      if (mode_d == ModeString) begin
        fresh = 1'b0;
        if (c == ChQuote) begin
          b      = emit(b, 8'h00, 1'b0, 1'b1, KindString);
          mode_d = ModeIdle;
        end else begin
          b = emit(b, c, 1'b1, 1'b0, KindIdent);
        end
      end else if (mode_d == ModeIdent) begin
        if (is_word(c)) begin
          fresh = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if (alive_d[k] && !kw_match(k, wlen_d, c)) begin
              alive_d[k] = 1'b0;
            end
          end
          if (wlen_d != 3'd7) begin
            wlen_d = wlen_d + 3'd1;
          end
          b = emit(b, c, 1'b1, 1'b0, KindIdent);
        end else begin
          b      = emit(b, 8'h00, 1'b0, 1'b1, ident_kind(alive_d, wlen_d));
          mode_d = ModeIdle;
        end
      end else if (mode_d == ModeNumber) begin
        if (is_digit(c)) begin
          fresh = 1'b0;
          b     = emit(b, c, 1'b1, 1'b0, KindIdent);
        end else begin
          b      = emit(b, 8'h00, 1'b0, 1'b1, KindNumber);
          mode_d = ModeIdle;
        end
      end
      if (fresh && (held_d != HeldNone)) begin
        if (c == ChEq) begin
          fresh = 1'b0;
          b     = emit(b, op_char(held_d), 1'b1, 1'b0, KindIdent);
          case (held_d)
            HeldPlus:  b = emit(b, c, 1'b1, 1'b1, KindPlusAssign);
            HeldMinus: b = emit(b, c, 1'b1, 1'b1, KindMinusAssign);
            default:   b = emit(b, c, 1'b1, 1'b1, KindMultAssign);
          endcase
          held_d = HeldNone;
        end else if ((held_d == HeldMinus) && is_digit(c)) begin
          fresh  = 1'b0;
          b      = emit(b, ChMinus, 1'b1, 1'b0, KindIdent);
          b      = emit(b, c, 1'b1, 1'b0, KindIdent);
          held_d = HeldNone;
          mode_d = ModeNumber;
        end else begin
          b      = emit(b, op_char(held_d), 1'b1, 1'b1, KindAssign);
          held_d = HeldNone;
        end
      end
      if (fresh && !is_space(c)) begin
        if (is_alpha(c) || (c == ChUnder)) begin
          mode_d = ModeIdent;
          for (int k = 0; k < 3; k++) begin
            alive_d[k] = kw_match(k, 3'd0, c);
          end
          wlen_d = 3'd1;
          b      = emit(b, c, 1'b1, 1'b0, KindIdent);
        end else if (is_digit(c)) begin
          mode_d = ModeNumber;
          b      = emit(b, c, 1'b1, 1'b0, KindIdent);
        end else if (c == ChQuote) begin
          mode_d = ModeString;
        end else if (c == ChPlus) begin
          held_d = HeldPlus;
        end else if (c == ChMinus) begin
          held_d = HeldMinus;
        end else if (c == ChStar) begin
          held_d = HeldStar;
        end else if (c == ChEq) begin
          b = emit(b, c, 1'b1, 1'b1, KindAssign);
        end else if (c == ChSemi) begin
          b = emit(b, c, 1'b1, 1'b1, KindSemicolon);
        end else begin
          b = emit(b, c, 1'b1, 1'b1, KindBadChar);
        end
      end
    end
    if (in_i.source_end) begin
      if (held_d != HeldNone) begin
        b = emit(b, op_char(held_d), 1'b1, 1'b1, KindAssign);
      end
      case (mode_d)
        ModeIdent:  b = emit(b, 8'h00, 1'b0, 1'b1, ident_kind(alive_d, wlen_d));
        ModeNumber: b = emit(b, 8'h00, 1'b0, 1'b1, KindNumber);
        ModeString: b = emit(b, 8'h00, 1'b0, 1'b1, KindString);
        default:    ;
      endcase
      b       = emit(b, 8'h00, 1'b0, 1'b1, KindEof);
      mode_d  = ModeIdle;
      held_d  = HeldNone;
      alive_d = 3'b111;
      wlen_d  = 3'd0;
    end
    if (b.cnt != '0) begin
      b.res[2'(b.cnt - CntW'(1))].last = 1'b1;
    end
  end

  assign wr_o     = accept_i && (b.cnt != '0);
  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      held_q  <= HeldNone;
      alive_q <= 3'b111;
      wlen_q  <= 3'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      alive_q <= alive_d;
      wlen_q  <= wlen_d;
    end
  end

endmodule

@@ sv/tlt_fifo.sv @@
module tlt_fifo #(
  parameter int Depth = tlt_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  tlt_pkg::bundle_t wdata_i,
  input  logic             rd_i,
  output tlt_pkg::bundle_t rdata_o,
  output logic             valid_o,
  output logic             full_o
);
  import tlt_pkg::*;

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Cw = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [Aw-1:0]   wptr_q, rptr_q;
  logic [Cw-1:0]   count_q;
  logic            do_wr, do_rd;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == Cw'(Depth));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + Aw'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + Aw'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + Cw'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - Cw'(1);
      end
    end
  end

endmodule

@@ sv/tlt_back.sv @@
module tlt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlt_pkg::bundle_t bundle_i,
  input  logic             bundle_valid_i,
  output logic             bundle_rd_o,
  input  logic             pop,
  output logic             empty,
  output tlt_pkg::out_t    out_data_o
);
  import tlt_pkg::*;

  bundle_t    cur_q;
  logic [1:0] idx_q;
  logic       valid_q;
  logic       at_end;
  logic       take;

  assign at_end      = ({1'b0, idx_q} + CntW'(1)) == cur_q.cnt;
  assign take        = bundle_valid_i && (!valid_q || (pop && at_end));
  assign bundle_rd_o = take;
  assign empty       = !valid_q;
  assign out_data_o  = cur_q.res[idx_q];

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (take) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop && valid_q) begin
      if (at_end) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

@@ sv/toy_language_tokenizer.sv @@
// Streaming tokenizer: source text goes in one byte per beat and token text
// comes out one character result per beat.
// Input channel: in_data_i carries text_byte, byte_present and source_end; a
// beat is taken when push is high and full is low. A beat with source_end set
// closes any open token and pending operator and ends with an eof result.
// Output channel: while empty is low, out_data_o holds the oldest result; it
// is taken when pop is high. The last flag marks the final result of a beat.
// An input beat's results are registered in the result queue and then in the output stage before they reach out_data_o.
// An input beat is taken in every cycle while push is high and the result queue
// has room; each beat yields zero to four results, and the output side delivers
// one result per cycle while pop is high, so throughput is one beat per cycle until
// multi-result bursts outpace the single-result output port.
// The queue holds QueueDepth beats' worth of results plus one beat in the
// output stage; full rises when the queue is full, so a stalled receiver holds
// back the sender without losing results.
// Reset clears the scanner state and empties the queue and the output stage.
module toy_language_tokenizer #(
  parameter int QueueDepth = tlt_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tlt_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output tlt_pkg::out_t out_data_o
);
  import tlt_pkg::*;

  logic    accept;
  logic    fifo_wr;
  logic    fifo_rd;
  logic    fifo_valid;
  bundle_t wr_bundle;
  bundle_t rd_bundle;

  assign accept = push && !full;

  tlt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .wr_o     (fifo_wr),
    .bundle_o (wr_bundle)
  );

  tlt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fifo_wr),
    .wdata_i (wr_bundle),
    .rd_i    (fifo_rd),
    .rdata_o (rd_bundle),
    .valid_o (fifo_valid),
    .full_o  (full)
  );

  tlt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_i       (rd_bundle),
    .bundle_valid_i (fifo_valid),
    .bundle_rd_o    (fifo_rd),
    .pop            (pop),
    .empty          (empty),
    .out_data_o     (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_wr_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_wr |-> !full) else $error("Result queue written while full.");

  a_wr_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_wr |-> (wr_bundle.cnt != '0)) else $error("Empty bundle queued.");

  a_kind_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.token_end) |-> (out_data_o.token_kind == KindIdent))
    else $error("Token kind set on a result that does not close a token.");

  a_rd_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_rd |-> fifo_valid) else $error("Result queue read while empty.");
`endif

endmodule
